[hdl/nwf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nwf_pkg: shared types and constants
// Constants, field widths and sequencer states of the normalized window filter.
// ----------------------------------------------------------------------------
package nwf_pkg;
	localparam int MaxKernel = 5;
	localparam int MaxWidth = 1024;
	localparam int MaxHeight = 1024;
	localparam int KW = 3;
	localparam int CW = 11;
	localparam int PW = 10;
	localparam int LAW = 12;
	localparam int SUMW = 21;
	localparam int ACCW = 56;
	localparam int QW = 36;
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KSIZE = 2'd2;
	localparam logic OP_COEF = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_MAC, ST_MAC_WAIT, ST_DIV, ST_OUT
	} state_t;

	function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v, input int hi);
		logic [CW-1:0] r;
		r = v;
		if (v == '0) r = CW'(1);
		else if (32'(v) > hi) r = CW'(hi);
		return r;
	endfunction

	function automatic logic [KW-1:0] clamp_k(input logic [KW-1:0] v);
		logic [KW-1:0] r;
		r = v;
		if (v == '0) r = KW'(1);
		else if (32'(v) > MaxKernel) r = KW'(MaxKernel);
		return r;
	endfunction
endpackage
`default_nettype wire

[hdl/nwf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nwf_ram: generic single-port-write, registered-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nwf_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hdl/normalized_2d_window_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_2d_window_filter: KxK valid-window correlation, normalized
// Coefficient loads keep a running kernel sum; pixels in raster order give one
// result for each full window, divided by the kernel sum toward zero.
// ----------------------------------------------------------------------------
// A coefficient transfer updates the kernel store and the kernel sum before
// input is taken again. A pixel transfer that completes a window runs its K*K
// taps through the single shared multiply-accumulate (one tap a cycle from the
// line buffer RAM), then the bit-serial restoring divider, then loads the
// output register with a valid result. Input is taken again in the cycle
// after the result transfer. Pixels without a full window may follow back to
// back. After reset and after each kernel_size write, a pass clears all 32
// entries of the kernel store. A configuration write takes priority over an
// input transfer offered in the same cycle.
module normalized_2d_window_filter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // coef_index[4:0], sample[20:5], zero fill
	input  wire         s_tuser,   // op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // filtered[35:0], out_row[45:36], out_col[55:46]
	output logic        m_tuser,   // zero_divisor
	output logic        m_tlast,   // last
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [10:0] cfg_data
);
	localparam int LADDR = $clog2(nwf_pkg::MaxKernel * nwf_pkg::MaxWidth);

	nwf_pkg::state_t state_q, state_d;
	logic [nwf_pkg::CW-1:0] width_q, height_q;
	logic [nwf_pkg::KW-1:0] ksize_q;
	logic signed [nwf_pkg::SUMW-1:0] ksum_q;
	logic [nwf_pkg::PW-1:0] row_q, col_q;
	logic [2:0] prow_q;
	logic [$clog2(nwf_pkg::MaxKernel)-1:0] lrow_q;
	logic [4:0] tap_q, ti_q, tj_q, clr_q;
	logic [2:0] ri_q;
	logic tap_valid_q;
	logic signed [nwf_pkg::ACCW-1:0] acc_q;
	logic [nwf_pkg::ACCW-1:0] dvd_q, rem_q;
	logic [nwf_pkg::SUMW-1:0] dvs_q;
	logic neg_q;
	logic [5:0] dcnt_q;
	logic [nwf_pkg::PW-1:0] r0_q, c0_q;
	logic last_q, coef_pend_q;
	logic [4:0] cidx_q;
	logic signed [15:0] csamp_q;

	logic [nwf_pkg::CW-1:0] w, h;
	logic [nwf_pkg::KW-1:0] k;
	logic in_fire, out_fire, cfg_fire;
	logic [4:0] in_idx;
	logic signed [15:0] in_samp;
	logic [nwf_pkg::PW-1:0] r, c;
	logic [2:0] rm;
	logic [3:0] r0m_sum;
	logic [2:0] r0m;
	logic win_ok;

	assign w = nwf_pkg::clamp_dim(width_q, nwf_pkg::MaxWidth);
	assign h = nwf_pkg::clamp_dim(height_q, nwf_pkg::MaxHeight);
	assign k = nwf_pkg::clamp_k(ksize_q);
	assign in_idx = s_tdata[4:0];
	assign in_samp = s_tdata[20:5];
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == nwf_pkg::ST_IDLE) && !m_tvalid && !coef_pend_q;
	assign s_tready = (state_q == nwf_pkg::ST_IDLE) && !m_tvalid && !coef_pend_q &&
		!cfg_valid;

	// Position wraps when it lies outside the current image.
	always_comb begin
		r = row_q;
		c = col_q;
		rm = prow_q;
		if ({1'b0, row_q} >= h || {1'b0, col_q} >= w) begin
			r = '0;
			c = '0;
			rm = '0;
		end
	end
	assign win_ok = ({8'd0, k} <= w) && ({8'd0, k} <= h) &&
		({1'b0, r} + 11'd1 >= {8'd0, k}) && ({1'b0, c} + 11'd1 >= {8'd0, k});

	// Line buffer row of the window's top row.
	assign r0m_sum = 4'(rm) + 4'(nwf_pkg::MaxKernel + 1) - 4'(k);
	assign r0m = (r0m_sum >= 4'(nwf_pkg::MaxKernel)) ?
		3'(r0m_sum - 4'(nwf_pkg::MaxKernel)) : 3'(r0m_sum);

	// Line buffer RAM: MaxKernel rows of MaxWidth pixels.
	logic lb_we;
	logic [LADDR-1:0] lb_waddr, lb_raddr;
	logic [15:0] lb_rdata;
	logic [2:0] rrow;
	logic [5:0] rrow_sum;
	assign rrow_sum = 6'(lrow_q) + 6'(ri_q);
	assign rrow = (rrow_sum >= 6'(nwf_pkg::MaxKernel)) ?
		3'(rrow_sum - 6'(nwf_pkg::MaxKernel)) : 3'(rrow_sum);
	assign lb_we = in_fire && (s_tuser == nwf_pkg::OP_PIXEL);
	assign lb_waddr = LADDR'(32'(rm) * nwf_pkg::MaxWidth + 32'(c));
	assign lb_raddr = LADDR'(32'(rrow) * nwf_pkg::MaxWidth + 32'(c0_q) + 32'(tj_q));

	nwf_ram #(.Width(16), .Depth(nwf_pkg::MaxKernel * nwf_pkg::MaxWidth)) u_line (
		.clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(in_samp),
		.raddr(lb_raddr), .rdata(lb_rdata)
	);

	// Kernel store RAM, read for coefficient replace and for taps.
	logic kr_we;
	logic [4:0] kr_waddr, kr_raddr;
	logic [15:0] kr_wdata, kr_rdata;
	always_comb begin
		kr_we = 1'b0;
		kr_waddr = cidx_q;
		kr_wdata = csamp_q;
		if (state_q == nwf_pkg::ST_CLEAR) begin
			kr_we = 1'b1;
			kr_waddr = clr_q;
			kr_wdata = '0;
		end else if (coef_pend_q) begin
			kr_we = 1'b1;
		end
		kr_raddr = (state_q == nwf_pkg::ST_IDLE) ? in_idx : tap_q;
	end

	nwf_ram #(.Width(16), .Depth(32)) u_kern (
		.clk(clk), .we(kr_we), .waddr(kr_waddr), .wdata(kr_wdata),
		.raddr(kr_raddr), .rdata(kr_rdata)
	);

	logic tap_last;
	assign tap_last = (ti_q == 5'(k) - 5'd1) && (tj_q == 5'(k) - 5'd1);
	logic [nwf_pkg::ACCW:0] trial;
	assign trial = {rem_q, dvd_q[nwf_pkg::ACCW-1]} - {36'd0, dvs_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nwf_pkg::ST_IDLE: begin
				if (cfg_fire && cfg_index == nwf_pkg::REG_KSIZE) state_d = nwf_pkg::ST_CLEAR;
				else if (lb_we && win_ok) state_d = nwf_pkg::ST_MAC;
			end
			nwf_pkg::ST_CLEAR: if (clr_q == 5'd31) state_d = nwf_pkg::ST_IDLE;
			nwf_pkg::ST_MAC: if (tap_last) state_d = nwf_pkg::ST_MAC_WAIT;
			nwf_pkg::ST_MAC_WAIT: if (!tap_valid_q) state_d = nwf_pkg::ST_DIV;
			nwf_pkg::ST_DIV: if (dcnt_q == 6'(nwf_pkg::ACCW - 1)) state_d = nwf_pkg::ST_OUT;
			nwf_pkg::ST_OUT: state_d = nwf_pkg::ST_IDLE;
			default: state_d = nwf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nwf_pkg::ST_CLEAR;
			width_q <= 11'd8;
			height_q <= 11'd8;
			ksize_q <= 3'd3;
			ksum_q <= '0;
			row_q <= '0;
			col_q <= '0;
			prow_q <= '0;
			clr_q <= '0;
			tap_valid_q <= 1'b0;
			coef_pend_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nwf_pkg::ST_CLEAR) clr_q <= clr_q + 5'd1;
			if (out_fire) m_tvalid <= 1'b0;
			coef_pend_q <= 1'b0;
			if (coef_pend_q) begin
				ksum_q <= ksum_q + nwf_pkg::SUMW'(csamp_q) - nwf_pkg::SUMW'($signed(kr_rdata));
			end
			if (cfg_fire) begin
				unique case (cfg_index)
					nwf_pkg::REG_WIDTH: begin
						width_q <= cfg_data;
						row_q <= '0;
						col_q <= '0;
						prow_q <= '0;
					end
					nwf_pkg::REG_HEIGHT: begin
						height_q <= cfg_data;
						row_q <= '0;
						col_q <= '0;
						prow_q <= '0;
					end
					nwf_pkg::REG_KSIZE: begin
						ksize_q <= cfg_data[2:0];
						ksum_q <= '0;
						clr_q <= '0;
						row_q <= '0;
						col_q <= '0;
						prow_q <= '0;
					end
					default: ;
				endcase
			end
			if (in_fire && s_tuser == nwf_pkg::OP_COEF) begin
				coef_pend_q <= ({1'b0, in_idx} < 6'(k) * 6'(k));
			end
			if (lb_we) begin
				if ({1'b0, c} + 11'd1 >= w) begin
					col_q <= '0;
					if ({1'b0, r} + 11'd1 >= h) begin
						row_q <= '0;
						prow_q <= '0;
					end else begin
						row_q <= r + 10'd1;
						prow_q <= (rm == 3'(nwf_pkg::MaxKernel - 1)) ? '0 : rm + 3'd1;
					end
				end else begin
					col_q <= c + 10'd1;
					row_q <= r;
					prow_q <= rm;
				end
			end
			tap_valid_q <= (state_q == nwf_pkg::ST_MAC);
			if (state_q == nwf_pkg::ST_OUT) m_tvalid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == nwf_pkg::OP_COEF) begin
			cidx_q <= in_idx;
			csamp_q <= in_samp;
		end
		if (lb_we && win_ok) begin
			r0_q <= r + 10'd1 - 10'(k);
			c0_q <= c + 10'd1 - 10'(k);
			lrow_q <= r0m;
			last_q <= ({1'b0, r} == h - 11'd1) && ({1'b0, c} == w - 11'd1);
			tap_q <= '0;
			ti_q <= '0;
			tj_q <= '0;
			ri_q <= '0;
			acc_q <= '0;
		end
		if (state_q == nwf_pkg::ST_MAC) begin
			tap_q <= tap_q + 5'd1;
			if (tj_q == 5'(k) - 5'd1) begin
				tj_q <= '0;
				ti_q <= ti_q + 5'd1;
				ri_q <= ri_q + 3'd1;
			end else begin
				tj_q <= tj_q + 5'd1;
			end
		end
		if (tap_valid_q) begin
			acc_q <= acc_q + nwf_pkg::ACCW'($signed(lb_rdata) * $signed(kr_rdata));
		end
		if (state_q == nwf_pkg::ST_MAC_WAIT && !tap_valid_q) begin
			dvd_q <= acc_q[nwf_pkg::ACCW-1] ? nwf_pkg::ACCW'(-acc_q) : acc_q;
			dvs_q <= ksum_q[nwf_pkg::SUMW-1] ? nwf_pkg::SUMW'(-ksum_q) : ksum_q;
			neg_q <= acc_q[nwf_pkg::ACCW-1] ^ ksum_q[nwf_pkg::SUMW-1];
			rem_q <= '0;
			dcnt_q <= '0;
		end
		if (state_q == nwf_pkg::ST_DIV) begin
			dcnt_q <= dcnt_q + 6'd1;
			if (!trial[nwf_pkg::ACCW]) begin
				rem_q <= trial[nwf_pkg::ACCW-1:0];
				dvd_q <= {dvd_q[nwf_pkg::ACCW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[nwf_pkg::ACCW-2:0], dvd_q[nwf_pkg::ACCW-1]};
				dvd_q <= {dvd_q[nwf_pkg::ACCW-2:0], 1'b0};
			end
		end
		if (state_q == nwf_pkg::ST_OUT) begin
			m_tdata[35:0] <= (ksum_q == '0) ? 36'd0 :
				(neg_q ? nwf_pkg::QW'(-dvd_q) : nwf_pkg::QW'(dvd_q));
			m_tdata[45:36] <= r0_q;
			m_tdata[55:46] <= c0_q;
			m_tuser <= (ksum_q == '0);
			m_tlast <= last_q;
		end
	end
endmodule
`default_nettype wire

[hdl/nwf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nwf_checker: port-level checks for the window filter
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
module nwf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        s_tvalid,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [55:0] m_tdata,
	input wire        m_tuser,
	input wire        cfg_valid,
	input wire        cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[35:0] == 36'd0)
		else $error("zero divisor with nonzero result");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready && !cfg_ready)
		else $error("input taken while result pending");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready && cfg_valid && cfg_ready))
		else $error("input and configuration transfer in the same cycle");
endmodule

bind normalized_2d_window_filter nwf_checker u_nwf_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .s_tvalid(s_tvalid),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire
